FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define SKT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Implication form: antecedent overlapping consequent.
`define SKT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `SKT_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Implication form: consequent in the next cycle.
`define SKT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  `SKT_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

FILE: rtl/skt_pkg.sv
// Shared constants, codes and types of the sorted key table.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package skt_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned CODE_W   = 17;
  localparam int unsigned COUNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned STATUS_W = 3;

  localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'(99999);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_RANGE    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_INSERT = 2'd1,
    SH_DELETE = 2'd2,
    SH_ROTATE = 2'd3
  } shift_e;

  typedef struct packed {
    shift_e            mode;
    logic [CODE_W-1:0] key;
  } cell_cmd_t;

endpackage

FILE: rtl/skt_cell.sv
// One cell of the sorted chain: holds a single code, compares it with the key
// and on insert, delete and rotate takes a neighbour's code, the key or the head code.
// Depends on skt_pkg.
`timescale 1ns / 1ps

module skt_cell import skt_pkg::*; (
  input  logic              clk_i,
  input  cell_cmd_t         cmd_i,
  input  logic              occ_i,
  input  logic              left_lt_i,
  input  logic [CODE_W-1:0] left_code_i,
  input  logic [CODE_W-1:0] right_code_i,
  input  logic [CODE_W-1:0] head_code_i,
  input  logic              wrap_i,
  output logic [CODE_W-1:0] code_o,
  output logic              lt_o,
  output logic              eq_o
);

  logic [CODE_W-1:0] code_q, code_d;

  assign lt_o   = occ_i & (code_q < cmd_i.key);
  assign eq_o   = occ_i & (code_q == cmd_i.key);
  assign code_o = code_q;

  always_comb begin
    case (cmd_i.mode)
      SH_INSERT: code_d = lt_o ? code_q : (left_lt_i ? cmd_i.key : left_code_i);
      SH_DELETE: code_d = lt_o ? code_q : right_code_i;
      SH_ROTATE: code_d = wrap_i ? head_code_i : right_code_i;
      default:   code_d = code_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

endmodule

FILE: rtl/skt_chain.sv
// Row of key cells kept in ascending order, with occupancy decoded from the
// entry count and the match reduction. Depends on skt_pkg and skt_cell.
`timescale 1ns / 1ps

module skt_chain import skt_pkg::*; (
  input  logic               clk_i,
  input  cell_cmd_t          cmd_i,
  input  logic [COUNT_W-1:0] count_i,
  output logic               match_o,
  output logic [CODE_W-1:0]  head_code_o
);

  logic [CODE_W-1:0]   codes [CAPACITY];
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] wrap;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic              left_lt;
    logic [CODE_W-1:0] left_code;
    logic [CODE_W-1:0] right_code;

    assign occ[i] = count_i > COUNT_W'(i);

    if (i == 0) begin : g_first
      assign left_lt   = 1'b1;
      assign left_code = cmd_i.key;
    end else begin : g_inner
      assign left_lt   = lt[i-1];
      assign left_code = codes[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_code = codes[i];
      assign wrap[i]    = occ[i];
    end else begin : g_body
      assign right_code = codes[i+1];
      assign wrap[i]    = occ[i] & ~occ[i+1];
    end

    skt_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd_i),
      .occ_i        (occ[i]),
      .left_lt_i    (left_lt),
      .left_code_i  (left_code),
      .right_code_i (right_code),
      .head_code_i  (codes[0]),
      .wrap_i       (wrap[i]),
      .code_o       (codes[i]),
      .lt_o         (lt[i]),
      .eq_o         (eq[i])
    );
  end

  assign match_o     = |eq;
  assign head_code_o = codes[0];

endmodule

FILE: rtl/sorted_key_table.sv
// Sorted key table: a set of up to CAPACITY unique codes kept in ascending
// order in a chain of compare-and-shift cells.
// Input channel: in_valid_i / in_stall_o carry opcode_i and item_code_i.
// Output channel: out_valid_o / out_stall_i carry status_o, found_o,
// listed_code_o and last_o; a beat moves when valid is high and stall low.
// Insert, delete and lookup compare the key in every cell at once and give
// one beat, registered in the cycle after the input beat; one such item is
// taken every cycle while the output is not stalled and no list is running.
// List rotates the chain one cell per output beat and presents the head
// cell, so it holds the input until every entry is listed; an empty table gives
// its single beat in the cycle after the input beat, as the other commands do.
// No input beat is taken until the final list beat is loaded.
// Reset clears the state, the entry count and the output valid flag; the cell
// codes are left as they are and are never read until written.
// While the receiver stalls, the pending beat holds and the block stalls its
// input once the output register is full.
// Depends on skt_pkg, skt_chain and skt_cell.
`timescale 1ns / 1ps

module sorted_key_table import skt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [CODE_W-1:0]   item_code_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic                found_o,
  output logic [CODE_W-1:0]   listed_code_o,
  output logic                last_o
);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  state_e             state_q;
  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] rem_q;
  logic               out_valid_q;
  status_e            status_q;
  logic               found_q;
  logic [CODE_W-1:0]  code_q;
  logic               last_q;

  logic              out_free;
  logic              in_take;
  logic              list_step;
  logic              out_load;
  logic              match;
  logic              range_err;
  logic              full;
  logic              ins_ok;
  logic              del_ok;
  logic [CODE_W-1:0] head_code;
  op_e               op;
  cell_cmd_t         cmd;
  status_e           res_status;
  logic              res_found;

  assign op        = op_e'(opcode_i);
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) | ~out_free;
  assign in_take   = in_valid_i & ~in_stall_o;
  assign list_step = (state_q == S_LIST) & out_free;
  assign out_load  = (in_take & ~((op == OP_LIST) & (count_q != '0))) | list_step;

  assign range_err = item_code_i > CODE_MAX;
  assign full      = count_q == COUNT_W'(CAPACITY);
  assign ins_ok    = in_take & (op == OP_INSERT) & ~range_err & ~match & ~full;
  assign del_ok    = in_take & (op == OP_DELETE) & match;

  always_comb begin
    cmd.key = item_code_i;
    if (ins_ok) begin
      cmd.mode = SH_INSERT;
    end else if (del_ok) begin
      cmd.mode = SH_DELETE;
    end else if (list_step) begin
      cmd.mode = SH_ROTATE;
    end else begin
      cmd.mode = SH_HOLD;
    end
  end

  always_comb begin
    case (op)
      OP_INSERT: begin
        res_found = 1'b0;
        if (range_err) begin
          res_status = ST_RANGE;
        end else if (match) begin
          res_status = ST_DUP;
          res_found  = 1'b1;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_OK;
        end
      end
      OP_DELETE, OP_LOOKUP: begin
        res_found  = match;
        res_status = match ? ST_OK : ST_NOTFOUND;
      end
      default: begin
        res_found  = 1'b0;
        res_status = ST_EMPTY;
      end
    endcase
  end

  skt_chain u_chain (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .count_i     (count_q),
    .match_o     (match),
    .head_code_o (head_code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      found_q     <= 1'b0;
      code_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_take) begin
        if (op == OP_LIST && count_q != '0) begin
          state_q <= S_LIST;
          rem_q   <= count_q;
        end else begin
          status_q    <= res_status;
          found_q     <= res_found;
          code_q      <= '0;
          last_q      <= 1'b1;
        end
        if (ins_ok) begin
          count_q <= count_q + COUNT_W'(1);
        end else if (del_ok) begin
          count_q <= count_q - COUNT_W'(1);
        end
      end
      if (list_step) begin
        status_q    <= ST_OK;
        found_q     <= 1'b1;
        code_q      <= head_code;
        last_q      <= rem_q == COUNT_W'(1);
        rem_q       <= rem_q - COUNT_W'(1);
        if (rem_q == COUNT_W'(1)) begin
          state_q <= S_IDLE;
        end
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_o       = found_q;
  assign listed_code_o = code_q;
  assign last_o        = last_q;

endmodule

FILE: rtl/skt_checker.sv
// Port-level checks of the sorted key table, bound to the top level.
// Depends on skt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module skt_checker import skt_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic [1:0]          opcode_i,
  input logic [CODE_W-1:0]   item_code_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [STATUS_W-1:0] status_o,
  input logic                found_o,
  input logic [CODE_W-1:0]   listed_code_o,
  input logic                last_o
);

  logic                       out_err;
  logic                       out_code;
  logic                       code_ok;
  logic                       out_found;
  logic                       found_ok;
  logic                       out_held;
  logic                       in_held;
  logic [STATUS_W+CODE_W+2:0] out_beat;
  logic [CODE_W+2:0]          in_beat;

  assign out_err   = out_valid_o && status_o != ST_OK;
  assign out_code  = out_valid_o && listed_code_o != '0;
  assign code_ok   = found_o && status_o == ST_OK && listed_code_o <= CODE_MAX;
  assign out_found = out_valid_o && found_o;
  assign found_ok  = status_o == ST_OK || status_o == ST_DUP;
  assign out_held  = out_valid_o && out_stall_i;
  assign in_held   = in_valid_i && in_stall_o;
  assign out_beat  = {out_valid_o, status_o, found_o, listed_code_o, last_o};
  assign in_beat   = {in_valid_i, opcode_i, item_code_i};

  `SKT_ASSERT_IMP(a_err_single, clk_i, rst_ni, out_err, last_o, "error beat not last")
  `SKT_ASSERT_IMP(a_code_listed, clk_i, rst_ni, out_code, code_ok, "bad listed code")
  `SKT_ASSERT_IMP(a_found_status, clk_i, rst_ni, out_found, found_ok, "found with error")
  `SKT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, $stable(out_beat), "stalled beat changed")
  `SKT_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_held, $stable(in_beat), "stalled input changed")

endmodule

bind sorted_key_table skt_checker u_skt_checker (.*);
